// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL. They expand to nothing when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/sida_pkg.sv =====
// ---------------------------------------------------------------------------
// sida_pkg
// Shared types, constants and helper functions of the signed integer to
// decimal ASCII converter.
// ---------------------------------------------------------------------------
package sida_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int CHAR_W             = 8;
  localparam int CHAR_COUNT_W       = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Number of decimal digits of the largest magnitude, 2^(vb-1).
  function automatic int dec_digits(input int vb);
    logic [63:0] p;
    int          n;
    p = 64'd1 << (vb - 1);
    n = 0;
    while (p != 64'd0) begin
      p = p / 64'd10;
      n++;
    end
    return n;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_shift;
    logic push_sign;
    logic push_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_bit;
    logic top_zero;
    logic last_digit;
    logic neg;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/sida_ctrl.sv =====
// ---------------------------------------------------------------------------
// sida_ctrl
// Sequencer of the converter: conversion, leading zero skip, sign and digit
// output.
// ---------------------------------------------------------------------------
module sida_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output sida_pkg::cmd_t cmd,
  input  sida_pkg::sts_t sts
);
  import sida_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.last_bit) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts.top_zero || sts.last_digit) begin
          state_nxt = sts.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sts.out_free && sts.last_digit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      ST_SKIP: begin
        cmd.skip_shift = sts.top_zero && !sts.last_digit;
      end
      ST_SIGN: begin
        cmd.push_sign = sts.out_free;
      end
      ST_DIGIT: begin
        cmd.push_digit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/sida_dp.sv =====
// ---------------------------------------------------------------------------
// sida_dp
// Datapath of the converter: magnitude shifter, BCD shift-and-add-3
// register, digit and character counters and the output word register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sida_dp #(
  parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [VALUE_BITS-1:0]      in_value,
  input  sida_pkg::cmd_t                    cmd,
  output sida_pkg::sts_t                    sts,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [sida_pkg::CHAR_W-1:0]       out_character,
  output logic                              out_is_last,
  output logic [sida_pkg::CHAR_COUNT_W-1:0] out_char_count
);
  import sida_pkg::*;

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * 4;
  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int DIG_W = $clog2(NDIG + 1);
  localparam int CNT_W = $clog2(NDIG + 2);

  logic [VALUE_BITS-1:0]   mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [BIT_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [DIG_W-1:0]        left_r, left_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [CHAR_COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [VALUE_BITS-1:0]   raw;
  logic [BCD_W-1:0]        bcd_adj;
  logic [3:0]              top_nib;
  logic [CNT_W-1:0]        cnt_inc;
  logic [CNT_W+3:0]        cnt_ext;
  logic                    out_free;

  assign raw      = in_value;
  assign top_nib  = bcd_r[BCD_W-1 -: 4];
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_ext  = {4'b0000, cnt_inc};
  assign out_free = !out_valid_r || !out_stall;

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < NDIG; i++) begin
      d = bcd_r[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    left_nxt      = left_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;

    if (cmd.load) begin
      neg_nxt     = raw[VALUE_BITS-1];
      mag_nxt     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
      bcd_nxt     = '0;
      bit_cnt_nxt = BIT_W'(VALUE_BITS - 1);
      left_nxt    = DIG_W'(NDIG);
      cnt_nxt     = '0;
    end
    if (cmd.conv_step) begin
      bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - BIT_W'(1);
    end
    if (cmd.skip_shift) begin
      bcd_nxt  = {bcd_r[BCD_W-5:0], 4'b0000};
      left_nxt = left_r - DIG_W'(1);
    end
    if (cmd.push_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
      out_count_nxt = '0;
      cnt_nxt       = cnt_inc;
    end
    if (cmd.push_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_ZERO + {4'b0000, top_nib};
      out_last_nxt  = sts.last_digit;
      out_count_nxt = sts.last_digit ? cnt_ext[CHAR_COUNT_W-1:0] : '0;
      cnt_nxt       = cnt_inc;
      bcd_nxt       = {bcd_r[BCD_W-5:0], 4'b0000};
      left_nxt      = left_r - DIG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    bcd_r       <= bcd_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    left_r      <= left_nxt;
    cnt_r       <= cnt_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    sts            = '0;
    sts.last_bit   = (bit_cnt_r == '0);
    sts.top_zero   = (top_nib == 4'd0);
    sts.last_digit = (left_r == DIG_W'(1));
    sts.neg        = neg_r;
    sts.out_free   = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_is_last    = out_last_r;
  assign out_char_count = out_count_r;

  `ASSERT_NEVER(a_one_cmd, clk, rst_n, !$onehot0(cmd), "more than one datapath command")
  `ASSERT_PROP(a_push_free, clk, rst_n,
               (cmd.push_sign || cmd.push_digit) |-> out_free, "word pushed over a waiting word")
  `ASSERT_PROP(a_bcd_digit, clk, rst_n,
               cmd.push_digit |-> (top_nib <= 4'd9), "BCD digit out of range")
  `ASSERT_PROP(a_skip_zero, clk, rst_n,
               cmd.skip_shift |-> (top_nib == 4'd0), "nonzero digit skipped")
  `ASSERT_PROP(a_last_count, clk, rst_n,
               (out_valid_r && out_last_r) |-> (out_count_r != '0), "last word without a count")

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one number at a time: a new number is accepted only once every
// word of the previous one has been pushed into the output register.
// The BCD conversion takes one bit per cycle and the leading zero scan
// one digit per cycle; sign and digit words then leave one per cycle
// while out_stall does not hold the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [VALUE_BITS-1:0]      in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sida_pkg::CHAR_W-1:0]       out_character,
  output logic                              out_is_last,
  output logic [sida_pkg::CHAR_COUNT_W-1:0] out_char_count
);
  import sida_pkg::*;

  // The converter handles one number at a time. When a number is accepted,
  // its sign is kept and its magnitude is formed; the most negative value
  // gives 2^(VALUE_BITS-1), which still fits the unsigned magnitude word.
  // The magnitude is then shifted MSB first into a BCD register, adding 3
  // to each digit of 5 or more before every shift (double dabble). After
  // that, leading zero digits are shifted out one per cycle, keeping at
  // least one digit so that zero gives a single '0'. Finally the sign and
  // the digits leave one word per cycle, unless out_stall holds, through a
  // single output register; a number's last word carries is_last and its word count.
  //
  // Because the last word sits in the output register while the sequencer
  // returns to idle, the next number can be accepted while that word still
  // waits to be taken.

  cmd_t cmd;
  sts_t sts;

  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  sida_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

endmodule
